/* hdl/hmlf_pkg.sv */
// Shared types, constants and character helpers for the HTTP message length framer.
`default_nettype none

package hmlf_pkg;

    // Width of the internal byte counters and of the length value.
    localparam int COUNT_WIDTH = 32;
    // Width of the count fields on the result port.
    localparam int OUT_WIDTH   = 32;
    // Number of characters in the header key.
    localparam int KEY_LEN     = 15;
    localparam int KEY_POS_W   = $clog2(KEY_LEN + 1);

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [KEY_POS_W-1:0]   t_key_pos;

    localparam t_count COUNT_MAX = '1;

    localparam logic [7:0]  CHR_CR       = 8'h0D;
    localparam logic [7:0]  CHR_LF       = 8'h0A;
    localparam logic [7:0]  CHR_TAB      = 8'h09;
    localparam logic [7:0]  CHR_VT       = 8'h0B;
    localparam logic [7:0]  CHR_FF       = 8'h0C;
    localparam logic [7:0]  CHR_SPACE    = 8'h20;
    localparam logic [7:0]  CHR_ZERO     = 8'h30;
    localparam logic [7:0]  CHR_NINE     = 8'h39;
    localparam logic [7:0]  CHR_UPPER_A  = 8'h41;
    localparam logic [7:0]  CHR_UPPER_Z  = 8'h5A;
    localparam logic [7:0]  CASE_OFFSET  = 8'h20;
    // The three bytes that precede the final LF of a blank line.
    localparam logic [23:0] TAIL_PATTERN = 24'h0D0A0D;

    // Phase of the value parser after the key has matched.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    // Header parsing state that the parser updates for each byte.
    typedef struct packed {
        logic     at_line_start;
        t_key_pos key_pos;
        t_phase   phase;
        t_count   length_value;
        logic     length_found;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        at_line_start: 1'b1,
        key_pos:       '0,
        phase:         PH_IDLE,
        length_value:  '0,
        length_found:  1'b0
    };

    // Lower-case key text, one character per position.
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            4'd14:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) ? c + CASE_OFFSET : c;
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        logic r;
        r = (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_VT) ||
            (c == CHR_FF) || (c == CHR_CR);
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        logic r;
        r = (c >= CHR_ZERO) && (c <= CHR_NINE);
        return r;
    endfunction

    // Low bits of a count as carried on the result port.
    function automatic logic [OUT_WIDTH-1:0] out_bits(input t_count v);
        logic [63:0] ext;
        ext = 64'(v);
        return ext[OUT_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/hmlf_parse.sv */
// Per-byte header parser: key match on each line and decimal value accumulation.
`default_nettype none

module hmlf_parse (
    input  wire logic [7:0]            i_byte,
    input  wire hmlf_pkg::t_parse_state i_state,
    output hmlf_pkg::t_parse_state      o_state,
    output logic                        o_overflow
);

    localparam int WIDE_W = hmlf_pkg::COUNT_WIDTH + 4;

    logic                         is_dig;
    logic                         is_nl;
    logic [WIDE_W-1:0]            wide_val;
    logic [WIDE_W-1:0]            digit_ext;
    logic                         add_ovf;
    hmlf_pkg::t_count             digit_val;
    hmlf_pkg::t_key_pos           pos;
    logic                         key_hit;
    logic                         key_done;
    logic                         take_digit;
    hmlf_pkg::t_phase             n_phase;

    assign is_dig = hmlf_pkg::is_digit(i_byte);
    assign is_nl  = (i_byte == hmlf_pkg::CHR_LF);

    // Next digit accumulation: value * 10 + d, with saturation on overflow.
    assign digit_ext = WIDE_W'(i_byte - hmlf_pkg::CHR_ZERO);
    assign wide_val  = (WIDE_W'(i_state.length_value) << 3) +
                       (WIDE_W'(i_state.length_value) << 1) + digit_ext;
    assign add_ovf   = (wide_val[WIDE_W-1:hmlf_pkg::COUNT_WIDTH] != '0);
    assign digit_val = add_ovf ? hmlf_pkg::COUNT_MAX
                               : wide_val[hmlf_pkg::COUNT_WIDTH-1:0];

    // Key comparison at the current line position.
    assign pos      = i_state.at_line_start ? '0 : i_state.key_pos;
    assign key_hit  = (i_state.at_line_start || pos != '0) &&
                      (pos < hmlf_pkg::t_key_pos'(hmlf_pkg::KEY_LEN)) &&
                      (hmlf_pkg::to_lower(i_byte) == hmlf_pkg::key_char(pos[3:0]));
    assign key_done = key_hit &&
                      (pos == hmlf_pkg::t_key_pos'(hmlf_pkg::KEY_LEN - 1));

    // Value phase next state.
    always_comb begin
        n_phase = i_state.phase;
        case (i_state.phase)
            hmlf_pkg::PH_SKIP: begin
                if (is_dig) begin
                    n_phase = hmlf_pkg::PH_DIGITS;
                end else if (!hmlf_pkg::is_blank(i_byte)) begin
                    n_phase = hmlf_pkg::PH_IDLE;
                end
            end
            hmlf_pkg::PH_DIGITS: begin
                if (!is_dig) begin
                    n_phase = hmlf_pkg::PH_IDLE;
                end
            end
            hmlf_pkg::PH_IDLE: begin
                if (!i_state.length_found && key_done) begin
                    n_phase = hmlf_pkg::PH_SKIP;
                end
            end
            default: n_phase = hmlf_pkg::PH_IDLE;
        endcase
    end

    assign take_digit = is_dig && ((i_state.phase == hmlf_pkg::PH_SKIP) ||
                                   (i_state.phase == hmlf_pkg::PH_DIGITS));

    // Datapath and key position updates.
    always_comb begin
        o_state               = i_state;
        o_state.phase         = n_phase;
        o_state.at_line_start = is_nl;
        o_overflow            = 1'b0;
        if (take_digit) begin
            o_state.length_value = digit_val;
            o_overflow           = add_ovf;
        end else if (i_state.phase == hmlf_pkg::PH_IDLE && !i_state.length_found) begin
            if (key_done) begin
                o_state.length_found = 1'b1;
                o_state.length_value = '0;
                o_state.key_pos      = '0;
            end else if (key_hit) begin
                o_state.key_pos = pos + 1'b1;
            end else begin
                o_state.key_pos = '0;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/http_message_length_framer_top.sv */
// Top level of the HTTP message length framer.
//
// Input channel: one message byte per transfer on i_data_byte, with
// i_start_of_buffer set on the first byte of a new message to clear all
// framing state before that byte is counted.
// Output channel: one result per input byte, giving header_found,
// message_complete, header_len, body_len and count_overflow for the
// message prefix received so far.
// Each input byte passes through the input register, and its result is
// loaded into the output register when the receiver does not stall.
// Throughput is one byte per cycle while the receiver does not stall;
// the per-byte state update is a single pass of compare logic and a
// constant multiply-add between the input register and the result register.
// Reset clears the state as for a fresh message and empties both stages.
// When the receiver stalls, the result register holds its value, the input
// register fills behind it and o_in_stall rises once both are occupied.
`default_nettype none

module http_message_length_framer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_start_of_buffer,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_header_found,
    output logic             o_message_complete,
    output logic [31:0]      o_header_len,
    output logic [31:0]      o_body_len,
    output logic             o_count_overflow
);

    // Input stage.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // Framing state.
    hmlf_pkg::t_count       r_byte_count;
    logic [23:0]            r_recent;
    hmlf_pkg::t_parse_state r_parse;
    logic                   r_header_done;
    hmlf_pkg::t_count       r_header_length;
    logic                   r_overflow;

    hmlf_pkg::t_count       n_byte_count;
    logic [23:0]            n_recent;
    hmlf_pkg::t_parse_state n_parse;
    logic                   n_header_done;
    hmlf_pkg::t_count       n_header_length;
    logic                   n_overflow;
    logic                   n_complete;

    // Current state, with a start flag treated as a fresh message.
    hmlf_pkg::t_count       cur_byte_count;
    logic [23:0]            cur_recent;
    hmlf_pkg::t_parse_state cur_parse;
    logic                   cur_header_done;
    hmlf_pkg::t_count       cur_header_length;
    logic                   cur_overflow;

    hmlf_pkg::t_parse_state parse_next;
    logic                   parse_ovf;
    hmlf_pkg::t_count       body_seen;

    logic out_ready;
    logic stage_move;

    assign out_ready  = !o_out_valid || !i_out_stall;
    assign stage_move = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;

    // Input register transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_start_of_buffer;
        end
    end

    always_comb begin
        cur_byte_count    = r_in_start ? '0 : r_byte_count;
        cur_recent        = r_in_start ? '0 : r_recent;
        cur_parse         = r_in_start ? hmlf_pkg::PARSE_RESET : r_parse;
        cur_header_done   = r_in_start ? 1'b0 : r_header_done;
        cur_header_length = r_in_start ? '0 : r_header_length;
        cur_overflow      = r_in_start ? 1'b0 : r_overflow;
    end

    hmlf_parse u_parse (
        .i_byte     (r_in_byte),
        .i_state    (cur_parse),
        .o_state    (parse_next),
        .o_overflow (parse_ovf)
    );

    // Next framing state for the byte in the input register.
    always_comb begin
        n_overflow      = cur_overflow;
        n_parse         = cur_parse;
        n_header_done   = cur_header_done;
        n_header_length = cur_header_length;
        if (cur_byte_count == hmlf_pkg::COUNT_MAX) begin
            n_byte_count = cur_byte_count;
            n_overflow   = 1'b1;
        end else begin
            n_byte_count = cur_byte_count + 1'b1;
        end
        if (!cur_header_done) begin
            n_parse    = parse_next;
            n_overflow = n_overflow | parse_ovf;
            if (r_in_byte == hmlf_pkg::CHR_LF && cur_recent == hmlf_pkg::TAIL_PATTERN) begin
                n_header_done   = 1'b1;
                n_header_length = n_byte_count;
                n_parse.phase   = hmlf_pkg::PH_IDLE;
            end
        end
        n_recent = {cur_recent[15:0], r_in_byte};
    end

    assign body_seen  = n_byte_count - n_header_length;
    assign n_complete = n_header_done && (n_byte_count >= n_header_length) &&
                        (body_seen >= n_parse.length_value);

    // State registers advance as each byte moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_recent        <= '0;
            r_parse         <= hmlf_pkg::PARSE_RESET;
            r_header_done   <= 1'b0;
            r_header_length <= '0;
            r_overflow      <= 1'b0;
        end else if (stage_move) begin
            r_byte_count    <= n_byte_count;
            r_recent        <= n_recent;
            r_parse         <= n_parse;
            r_header_done   <= n_header_done;
            r_header_length <= n_header_length;
            r_overflow      <= n_overflow;
        end
    end

    // Result register transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_ready) begin
            o_out_valid <= r_in_valid;
        end
        if (stage_move) begin
            o_header_found     <= n_header_done;
            o_message_complete <= n_complete;
            o_header_len       <= n_header_done ? hmlf_pkg::out_bits(n_header_length) : '0;
            o_body_len         <= n_header_done ? hmlf_pkg::out_bits(n_parse.length_value)
                                                : '0;
            o_count_overflow   <= n_overflow;
        end
    end

endmodule

`default_nettype wire

/* hdl/hmlf_checker.sv */
// Port-level checks for the HTTP message length framer, bound to the top level.
`default_nettype none

module hmlf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_header_found,
    input wire logic        o_message_complete,
    input wire logic [31:0] o_header_len,
    input wire logic [31:0] o_body_len
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A message cannot be complete before its header has ended.
    a_complete_needs_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_message_complete |-> o_header_found)
        else $error("complete without header");

    // Before the header ends the length fields read zero; after it the
    // header holds at least the blank line sequence.
    a_fields_vs_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_header_found ? (o_header_len >= 32'd4)
                                        : (o_header_len == '0 && o_body_len == '0)))
        else $error("length fields inconsistent with header state");

endmodule

bind http_message_length_framer_top hmlf_checker u_hmlf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_header_found     (o_header_found),
    .o_message_complete (o_message_complete),
    .o_header_len       (o_header_len),
    .o_body_len         (o_body_len)
);

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the HTTP message length framer top level.
`timescale 1ns / 1ps
`default_nettype none

module tb;

    // One input transfer as queued for the driver.
    typedef struct {
        logic [7:0]  data;
        logic        sob;
        logic        drain;
        int unsigned gap;
    } t_byte_xfer;

    // One expected framing result.
    typedef struct {
        logic        hdr;
        logic        done;
        logic [31:0] hbytes;
        logic [31:0] bbytes;
        logic        ovf;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_start_of_buffer = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_header_found;
    logic        o_message_complete;
    logic [31:0] o_header_len;
    logic [31:0] o_body_len;
    logic        o_count_overflow;

    t_byte_xfer    pending_bytes[$];
    logic [7:0]    msg_bytes[$];
    t_frame_result expected_frames[$];
    t_byte_xfer    cur_xfer;
    bit            have_xfer;
    int unsigned   gap_left;
    int unsigned   hold_left;
    int unsigned   bytes_sent;
    int unsigned   results_seen;
    int unsigned   failures;
    int unsigned   msg_count;

    // Framer state as predicted by the testbench.
    hmlf_pkg::t_count seen_count;
    logic [23:0]      last_three;
    logic             line_start;
    int unsigned      key_pos;
    hmlf_pkg::t_phase val_phase;
    hmlf_pkg::t_count content_len;
    logic             key_seen;
    logic             hdr_done;
    hmlf_pkg::t_count hdr_len;
    logic             sat_seen;

    localparam string KEY_TEXT = "content-length:";

    http_message_length_framer_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_start_of_buffer  (i_start_of_buffer),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_header_found     (o_header_found),
        .o_message_complete (o_message_complete),
        .o_header_len       (o_header_len),
        .o_body_len         (o_body_len),
        .o_count_overflow   (o_count_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Return the predicted framing state to that of a fresh message.
    function automatic void clear_frame_state();
        seen_count  = '0;
        last_three  = '0;
        line_start  = 1'b1;
        key_pos     = 0;
        val_phase   = hmlf_pkg::PH_IDLE;
        content_len = '0;
        key_seen    = 1'b0;
        hdr_done    = 1'b0;
        hdr_len     = '0;
        sat_seen    = 1'b0;
    endfunction

    // Fold one decimal digit into the length value, saturating at the top.
    function automatic void take_digit(input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] mx;
        d  = 64'(c - hmlf_pkg::CHR_ZERO);
        mx = 64'(hmlf_pkg::COUNT_MAX);
        if (64'(content_len) > (mx - d) / 64'd10) begin
            content_len = hmlf_pkg::COUNT_MAX;
            sat_seen    = 1'b1;
        end else begin
            content_len = hmlf_pkg::t_count'(64'(content_len) * 64'd10 + d);
        end
    endfunction

    // Advance the predicted framer by one byte and return its result.
    function automatic t_frame_result frame_byte(input logic [7:0] c, input logic sob);
        t_frame_result r;
        logic [7:0]    lc;
        logic          is_dig;
        logic          is_blk;
        int unsigned   pos;
        lc     = (c >= hmlf_pkg::CHR_UPPER_A && c <= hmlf_pkg::CHR_UPPER_Z)
                 ? c + hmlf_pkg::CASE_OFFSET : c;
        is_dig = (c >= hmlf_pkg::CHR_ZERO) && (c <= hmlf_pkg::CHR_NINE);
        is_blk = (c == hmlf_pkg::CHR_SPACE) || (c == hmlf_pkg::CHR_TAB) ||
                 (c == hmlf_pkg::CHR_VT) || (c == hmlf_pkg::CHR_FF) ||
                 (c == hmlf_pkg::CHR_CR);
        if (sob)
            clear_frame_state();
        if (seen_count == hmlf_pkg::COUNT_MAX)
            sat_seen = 1'b1;
        else
            seen_count = seen_count + 1'b1;

        // Key and value parsing runs only until the blank line.
        if (!hdr_done) begin
            case (val_phase)
                hmlf_pkg::PH_SKIP: begin
                    if (is_dig) begin
                        take_digit(c);
                        val_phase = hmlf_pkg::PH_DIGITS;
                    end else if (!is_blk) begin
                        val_phase = hmlf_pkg::PH_IDLE;
                    end
                end
                hmlf_pkg::PH_DIGITS: begin
                    if (is_dig)
                        take_digit(c);
                    else
                        val_phase = hmlf_pkg::PH_IDLE;
                end
                default: begin
                    if (!key_seen) begin
                        pos = line_start ? 0 : key_pos;
                        if ((line_start || pos != 0) && pos < hmlf_pkg::KEY_LEN &&
                            lc == KEY_TEXT[pos]) begin
                            pos++;
                            if (pos == hmlf_pkg::KEY_LEN) begin
                                key_seen    = 1'b1;
                                content_len = '0;
                                val_phase   = hmlf_pkg::PH_SKIP;
                                pos         = 0;
                            end
                            key_pos = pos;
                        end else begin
                            key_pos = 0;
                        end
                    end
                end
            endcase
            line_start = (c == hmlf_pkg::CHR_LF);
            if (c == hmlf_pkg::CHR_LF && last_three == hmlf_pkg::TAIL_PATTERN) begin
                hdr_done  = 1'b1;
                hdr_len   = seen_count;
                val_phase = hmlf_pkg::PH_IDLE;
            end
        end
        last_three = {last_three[15:0], c};

        r.hdr    = hdr_done;
        r.done   = hdr_done && (seen_count >= hdr_len) &&
                   (seen_count - hdr_len >= content_len);
        r.hbytes = hdr_done ? 32'(hdr_len) : 32'd0;
        r.bbytes = hdr_done ? 32'(content_len) : 32'd0;
        r.ovf    = sat_seen;
        return r;
    endfunction

    // Driver: offers queued bytes, holding each one until its transfer.
    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            i_in_valid        <= 1'b0;
            i_data_byte       <= 8'h00;
            i_start_of_buffer <= 1'b0;
            have_xfer = 0;
            gap_left  = 0;
            clear_frame_state();
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_frames.push_back(frame_byte(i_data_byte, i_start_of_buffer));
                bytes_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                offer = 1'b0;
                if (!have_xfer && pending_bytes.size() != 0) begin
                    cur_xfer  = pending_bytes.pop_front();
                    have_xfer = 1;
                    gap_left  = cur_xfer.gap;
                end
                if (have_xfer) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else if (!(cur_xfer.drain && results_seen != bytes_sent)) begin
                        offer     = 1'b1;
                        have_xfer = 0;
                    end
                end
                i_in_valid <= offer;
                if (offer) begin
                    i_data_byte       <= cur_xfer.data;
                    i_start_of_buffer <= cur_xfer.sob;
                end
            end
        end
    end

    // Monitor: checks each result transfer and draws the next stall.
    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    $error("result transfer with no byte outstanding");
                    failures++;
                end else begin
                    want = expected_frames.pop_front();
                    if (o_header_found !== want.hdr) begin
                        $error("header_found: expected %0d, got %0d",
                               want.hdr, o_header_found);
                        failures++;
                    end
                    if (o_message_complete !== want.done) begin
                        $error("message_complete: expected %0d, got %0d",
                               want.done, o_message_complete);
                        failures++;
                    end
                    if (o_header_len !== want.hbytes) begin
                        $error("header_len: expected %0d, got %0d",
                               want.hbytes, o_header_len);
                        failures++;
                    end
                    if (o_body_len !== want.bbytes) begin
                        $error("body_len: expected %0d, got %0d",
                               want.bbytes, o_body_len);
                        failures++;
                    end
                    if (o_count_overflow !== want.ovf) begin
                        $error("count_overflow: expected %0d, got %0d",
                               want.ovf, o_count_overflow);
                        failures++;
                    end
                end
                results_seen++;
                // One long hold-off lets the block fill up and stall its input.
                if (results_seen == 700)
                    hold_left = 60;
                else if ((results_seen / 300) % 4 == 2)
                    hold_left = 0;
                else
                    hold_left = $urandom_range(0, 4);
            end else if (hold_left != 0) begin
                hold_left--;
            end
            i_out_stall <= (hold_left != 0);
        end
    end

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_bytes.push_back(s[i]);
    endtask

    // Key text with each letter in random case.
    task automatic append_key(input string s);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++) begin
            ch = s[i];
            if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1)
                ch = ch - hmlf_pkg::CASE_OFFSET;
            msg_bytes.push_back(ch);
        end
    endtask

    task automatic append_blank();
        case ($urandom_range(0, 4))
            0:       msg_bytes.push_back(hmlf_pkg::CHR_SPACE);
            1:       msg_bytes.push_back(hmlf_pkg::CHR_TAB);
            2:       msg_bytes.push_back(hmlf_pkg::CHR_VT);
            3:       msg_bytes.push_back(hmlf_pkg::CHR_FF);
            default: msg_bytes.push_back(hmlf_pkg::CHR_CR);
        endcase
    endtask

    // Line end: mostly CR LF, sometimes a bare LF.
    task automatic append_eol();
        if ($urandom_range(0, 9) != 0)
            msg_bytes.push_back(hmlf_pkg::CHR_CR);
        msg_bytes.push_back(hmlf_pkg::CHR_LF);
    endtask

    // Move the built message into the driver queue.
    task automatic send_message(input logic sob, input logic drain);
        t_byte_xfer x;
        for (int i = 0; i < msg_bytes.size(); i++) begin
            x.data  = msg_bytes[i];
            x.sob   = sob && (i == 0);
            x.drain = drain && (i == 0);
            x.gap   = ((pending_bytes.size() / 250) % 4 == 3) ? 0 : $urandom_range(0, 4);
            pending_bytes.push_back(x);
        end
        msg_bytes.delete();
    endtask

    // A message with random headers, values and body; not every header line is well-formed.
    task automatic build_message();
        string       val;
        int unsigned body_hint;
        int unsigned nbody;
        int unsigned cut;
        bit          have_hint;
        body_hint = $urandom_range(0, 6);
        have_hint = 0;
        case ($urandom_range(0, 2))
            0:       append_text("GET / HTTP/1.1");
            1:       append_text("POST /upload HTTP/1.1");
            default: append_text("HTTP/1.1 200 OK");
        endcase
        append_eol();
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    append_key(KEY_TEXT);
                    repeat ($urandom_range(0, 3)) append_blank();
                    case ($urandom_range(0, 7))
                        0: val = "";
                        1: val = $sformatf("%0d", $urandom_range(0, 99999));
                        2: begin
                            // Long enough that it can saturate the length value.
                            val = "";
                            repeat ($urandom_range(10, 14))
                                val = $sformatf("%s%0d", val, $urandom_range(0, 9));
                        end
                        default: val = $sformatf("%0d", $urandom_range(0, 24));
                    endcase
                    if ($urandom_range(0, 5) == 0)
                        val = {"0", val};
                    if (!have_hint) begin
                        have_hint = 1;
                        if (val.len() <= 3 && val.atoi() <= 40)
                            body_hint = val.atoi();
                    end
                    append_text(val);
                    if ($urandom_range(0, 3) == 0)
                        msg_bytes.push_back(8'($urandom_range(0, 255)));
                end
                4: begin
                    case ($urandom_range(0, 3))
                        0: append_key("content-lengt: 5");
                        1: begin
                            msg_bytes.push_back(hmlf_pkg::CHR_SPACE);
                            append_key("content-length: 7");
                        end
                        2: append_key("content-length 9");
                        default: append_key("x-content-length: 4");
                    endcase
                end
                5, 6: append_text($sformatf("Host: srv%0d", $urandom_range(0, 9)));
                7: repeat ($urandom_range(1, 6))
                       msg_bytes.push_back(8'($urandom_range(0, 255)));
                default: append_text($sformatf("X-Id: %0d", $urandom_range(0, 999)));
            endcase
            append_eol();
        end
        msg_bytes.push_back(hmlf_pkg::CHR_CR);
        msg_bytes.push_back(hmlf_pkg::CHR_LF);

        // Body around the announced length, sometimes one byte short.
        nbody = body_hint + $urandom_range(0, 3);
        if (body_hint != 0 && $urandom_range(0, 3) == 0)
            nbody = body_hint - 1;
        for (int i = 0; i < nbody; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                append_text("Content-Length: 3");
                msg_bytes.push_back(hmlf_pkg::CHR_CR);
                msg_bytes.push_back(hmlf_pkg::CHR_LF);
                msg_bytes.push_back(hmlf_pkg::CHR_CR);
                msg_bytes.push_back(hmlf_pkg::CHR_LF);
            end else begin
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end

        // Some messages are cut short by the next start.
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > cut)
                void'(msg_bytes.pop_back());
        end
    endtask

    // Noise: short runs of bytes that stress the pattern and key logic.
    task automatic build_noise();
        repeat ($urandom_range(1, 20)) begin
            case ($urandom_range(0, 4))
                0:       msg_bytes.push_back(8'($urandom_range(0, 255)));
                1:       msg_bytes.push_back(hmlf_pkg::CHR_CR);
                2:       msg_bytes.push_back(hmlf_pkg::CHR_LF);
                3:       msg_bytes.push_back(hmlf_pkg::CHR_ZERO + 8'($urandom_range(0, 9)));
                default: msg_bytes.push_back(KEY_TEXT[$urandom_range(0, hmlf_pkg::KEY_LEN - 1)]);
            endcase
        end
    endtask

    // Stimulus, reset and end of run.
    initial begin
        // Empty header, complete at once, then the byte extremes as body.
        msg_bytes = '{hmlf_pkg::CHR_CR, hmlf_pkg::CHR_LF, hmlf_pkg::CHR_CR,
                      hmlf_pkg::CHR_LF, 8'h00, 8'hFF};
        send_message(1'b1, 1'b0);
        // High bytes and bare line feeds ahead of the blank line.
        msg_bytes = '{8'hFF, 8'h80, hmlf_pkg::CHR_LF, hmlf_pkg::CHR_LF,
                      hmlf_pkg::CHR_CR, hmlf_pkg::CHR_LF, hmlf_pkg::CHR_CR,
                      hmlf_pkg::CHR_LF};
        send_message(1'b1, 1'b1);
        // A new start in the middle of the end pattern must clear it.
        msg_bytes = '{hmlf_pkg::CHR_CR, hmlf_pkg::CHR_LF, hmlf_pkg::CHR_CR};
        send_message(1'b1, 1'b0);
        msg_bytes = '{hmlf_pkg::CHR_LF};
        send_message(1'b1, 1'b0);

        msg_count = 0;
        while (pending_bytes.size() < 2000) begin
            msg_count++;
            if ($urandom_range(0, 9) == 0) begin
                build_noise();
                send_message($urandom_range(0, 1), 1'b0);
            end else begin
                build_message();
                send_message(1'b1, msg_count % 40 == 0);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_bytes.size() != 0 || have_xfer || i_in_valid);
        do @(posedge i_clk);
        while (results_seen != bytes_sent);
        repeat (20) @(posedge i_clk);

        if (expected_frames.size() != 0) begin
            $error("%0d results never arrived", expected_frames.size());
            failures++;
        end
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
